[rtl/core/sha256md_pkg.sv]
// Shared types, constants and round functions for the SHA-256 digest unit.
`default_nettype none

package sha256md_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumHash = 8;
  localparam int unsigned NumWin  = 16;
  localparam int unsigned TotalW  = 61;

  localparam logic [1:0] BSEL_IN   = 2'd0;
  localparam logic [1:0] BSEL_PAD  = 2'd1;
  localparam logic [1:0] BSEL_ZERO = 2'd2;
  localparam logic [1:0] BSEL_LEN  = 2'd3;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       count_byte;
    logic       comp_start;
    logic       round_en;
    logic       fold;
    logic       out_next;
    logic       restart;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       rnd_last;
    logic       idx_last;
  } sts_t;

  function automatic word_t init_hash(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    word_t r;
    case (t)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

`default_nettype wire

[rtl/core/sha256md_dp.sv]
// Datapath: message window, working variables, hash words and counters.
`default_nettype none

module sha256md_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha256md_pkg::cmd_t   cmd,
  input  logic [7:0]           in_msg_byte,
  output sha256md_pkg::sts_t   sts,
  output sha256md_pkg::word_t  digest_word,
  output logic [2:0]           word_index
);

  sha256md_pkg::word_t h_r [sha256md_pkg::NumHash];
  sha256md_pkg::word_t v_r [sha256md_pkg::NumHash];
  sha256md_pkg::word_t w_r [sha256md_pkg::NumWin];
  logic [5:0]                      fill_r;
  logic [sha256md_pkg::TotalW-1:0] total_r;
  logic [5:0]                      rnd_r;
  logic [2:0]                      idx_r;

  logic [63:0]         len_bits;
  logic [63:0]         len_shift;
  logic [2:0]          len_pos;
  logic [7:0]          wr_byte;
  logic [1:0]          lane;
  sha256md_pkg::word_t t1;
  sha256md_pkg::word_t t2;
  sha256md_pkg::word_t w_new;

  assign len_bits  = {total_r, 3'b000};
  assign len_pos   = 3'd7 - fill_r[2:0];
  assign len_shift = len_bits >> {len_pos, 3'b000};
  assign lane      = 2'd3 - fill_r[1:0];

  always_comb begin
    case (cmd.wr_sel)
      sha256md_pkg::BSEL_IN:   wr_byte = in_msg_byte;
      sha256md_pkg::BSEL_PAD:  wr_byte = sha256md_pkg::PAD_BYTE;
      sha256md_pkg::BSEL_ZERO: wr_byte = 8'h00;
      default:                 wr_byte = len_shift[7:0];
    endcase
  end

  always_comb begin
    t1 = v_r[7] + sha256md_pkg::big_sigma1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
       + sha256md_pkg::round_k(rnd_r) + w_r[0];
    t2 = sha256md_pkg::big_sigma0(v_r[0])
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = sha256md_pkg::small_sigma1(w_r[14]) + w_r[9]
          + sha256md_pkg::small_sigma0(w_r[1]) + w_r[0];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      w_r[fill_r[5:2]][{lane, 3'b000} +: 8] <= wr_byte;
    end else if (cmd.round_en) begin
      for (int i = 0; i < sha256md_pkg::NumWin - 1; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[sha256md_pkg::NumWin-1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.comp_start) begin
      for (int i = 0; i < sha256md_pkg::NumHash; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (cmd.round_en) begin
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.restart) begin
      for (int i = 0; i < sha256md_pkg::NumHash; i++) begin
        h_r[i] <= sha256md_pkg::init_hash(3'(i));
      end
      fill_r  <= '0;
      total_r <= '0;
      rnd_r   <= '0;
      idx_r   <= '0;
    end else begin
      if (cmd.fold) begin
        for (int i = 0; i < sha256md_pkg::NumHash; i++) begin
          h_r[i] <= h_r[i] + v_r[i];
        end
      end
      if (cmd.wr_en) begin
        fill_r <= fill_r + 6'd1;
      end
      if (cmd.count_byte) begin
        total_r <= total_r + 61'd1;
      end
      if (cmd.comp_start) begin
        rnd_r <= '0;
      end else if (cmd.round_en) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.out_next) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  assign sts.fill     = fill_r;
  assign sts.rnd_last = (rnd_r == 6'd63);
  assign sts.idx_last = (idx_r == 3'd7);

  assign digest_word = h_r[idx_r];
  assign word_index  = idx_r;

endmodule

`default_nettype wire

[rtl/core/sha256md_ctrl.sv]
// Controller: input handshake, padding sequence, compression and digest output.
`default_nettype none

module sha256md_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_has_byte,
  input  logic               in_last,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  sha256md_pkg::sts_t sts,
  output sha256md_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PAD80  = 3'd1;
  localparam logic [2:0] S_PADZ   = 3'd2;
  localparam logic [2:0] S_PADLEN = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_FOLD   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       closing_r, closing_nxt;
  logic       padded_r, padded_nxt;
  logic       final_r, final_nxt;
  logic       in_acc;
  logic       fill_end;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign in_acc    = in_valid && !in_stall;
  assign fill_end  = (sts.fill == 6'd63);

  always_comb begin
    state_nxt   = state_r;
    closing_nxt = closing_r;
    padded_nxt  = padded_r;
    final_nxt   = final_r;
    cmd         = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_has_byte) begin
            cmd.wr_en      = 1'b1;
            cmd.wr_sel     = sha256md_pkg::BSEL_IN;
            cmd.count_byte = 1'b1;
          end
          if (in_has_byte && fill_end) begin
            cmd.comp_start = 1'b1;
            closing_nxt    = in_last;
            state_nxt      = S_ROUND;
          end else if (in_last) begin
            closing_nxt = 1'b1;
            state_nxt   = S_PAD80;
          end
        end
      end
      S_PAD80: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = sha256md_pkg::BSEL_PAD;
        padded_nxt = 1'b1;
        if (fill_end) begin
          cmd.comp_start = 1'b1;
          state_nxt      = S_ROUND;
        end else begin
          state_nxt = S_PADZ;
        end
      end
      S_PADZ: begin
        if (sts.fill == 6'd56) begin
          state_nxt = S_PADLEN;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = sha256md_pkg::BSEL_ZERO;
          if (fill_end) begin
            cmd.comp_start = 1'b1;
            state_nxt      = S_ROUND;
          end
        end
      end
      S_PADLEN: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = sha256md_pkg::BSEL_LEN;
        if (fill_end) begin
          cmd.comp_start = 1'b1;
          final_nxt      = 1'b1;
          state_nxt      = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round_en = 1'b1;
        if (sts.rnd_last) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd.fold = 1'b1;
        if (!closing_r) begin
          state_nxt = S_IDLE;
        end else if (final_r) begin
          state_nxt = S_OUT;
        end else if (!padded_r) begin
          state_nxt = S_PAD80;
        end else begin
          state_nxt = S_PADZ;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          cmd.out_next = 1'b1;
          if (sts.idx_last) begin
            cmd.restart = 1'b1;
            closing_nxt = 1'b0;
            padded_nxt  = 1'b0;
            final_nxt   = 1'b0;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      closing_r <= 1'b0;
      padded_r  <= 1'b0;
      final_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      closing_r <= closing_nxt;
      padded_r  <= padded_nxt;
      final_r   <= final_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/core/sha256_message_digest_unit.sv]
// SHA-256 message digest unit: top level joining controller and datapath.
// Input channel: one transaction per message byte (in_msg_byte, in_has_byte,
// in_last); in_has_byte low with in_last high closes a message with no byte.
// Output channel: eight transactions per message, digest words 0..7 with
// out_word_index and out_last_word on the eighth.
// Throughput: a byte is taken every cycle while a 64-byte block fills. The
// 64th byte starts a compression (64 rounds on one shared round unit, then
// an add into the hash words), during which in_stall is high.
// Closing: padding (0x80, zeros, eight length bytes) is written byte by byte
// into the block window, then one or two compressions follow, then the eight
// words leave at up to one per cycle. The worst case from the closing
// transaction to the first digest word is a close with 56 bytes held, so the
// padding spills into a second block.
// The input stays stalled from the closing transaction until the eighth word
// is taken; while out_stall is high the current word holds steady.
// Reset (rst_n low, synchronous) loads the initial hash values and clears the
// byte counts; after the eighth word the unit returns to that state by itself.
`default_nettype none

module sha256_message_digest_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha256md_pkg::cmd_t cmd;
  sha256md_pkg::sts_t sts;

  sha256md_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_has_byte (in_has_byte),
    .in_last     (in_last),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  sha256md_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_msg_byte (in_msg_byte),
    .sts         (sts),
    .digest_word (out_digest_word),
    .word_index  (out_word_index)
  );

  assign out_last_word = (out_word_index == 3'd7);

  a_no_input_during_output: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while digest is being delivered");

  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> (!out_valid && out_word_index == 3'd0))
    else $error("digest output did not finish after the last word");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest word index did not advance by one");

  a_first_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_word_index == 3'd0))
    else $error("digest output did not start at word zero");

endmodule

`default_nettype wire
